// ----- src/h2b_pkg.sv -----
// ----------------------------------------------------------------------------
// h2b_pkg
// Types and fixed widths shared by the 2D histogram binner and its channels.
// ----------------------------------------------------------------------------
package h2b_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int WIDTH_W   = 31;
  localparam int ROWCOL_W  = 6;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_START = 2'd0,
    CFG_RANGE_END   = 2'd1,
    CFG_BIN_WIDTH   = 2'd2
  } cfg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WIDTH_W-1:0]         bin_width_t;
  typedef logic [ROWCOL_W-1:0]        rowcol_t;
  typedef logic [OUT_W-1:0]           count_out_t;

endpackage

// ----- src/h2b_if.sv -----
// ----------------------------------------------------------------------------
// h2b channel interfaces
// Valid/ready channels for samples and reads, counter results and register
// writes.
// ----------------------------------------------------------------------------
interface h2b_in_if;
  logic             valid;
  logic             ready;
  h2b_pkg::op_t     operation;
  h2b_pkg::sample_t sample_x;
  h2b_pkg::sample_t sample_y;
  h2b_pkg::rowcol_t read_row;
  h2b_pkg::rowcol_t read_col;

  modport source (output valid, operation, sample_x, sample_y, read_row, read_col,
                  input ready);
  modport sink   (input valid, operation, sample_x, sample_y, read_row, read_col,
                  output ready);
endinterface

interface h2b_out_if;
  logic                valid;
  logic                ready;
  h2b_pkg::count_out_t bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

interface h2b_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [h2b_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [h2b_pkg::SAMPLE_W-1:0]      data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ----- src/histogram_2d_binner.sv -----
// ----------------------------------------------------------------------------
// histogram_2d_binner
// Bins signed sample pairs into a MAX_BINS x MAX_BINS grid of saturating
// counters held in one synchronous RAM; read transactions return one counter.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         accepted when
//  in_ch    in   operation, sample_x, sample_y, read_row/col     valid & ready
//  out_ch   out  bin_count (read transactions only)              valid & ready
//  cfg_ch   in   reg_index, data                                 valid & ready
//
//  Add: the 32-step radix-2 divider (three lanes: x, y and bin count), then
//  bin clamp, index, RAM read and write back; no new transaction is taken until it is done.
//  Read: one RAM read, then the output register; it holds if the output register is still full.
//  After reset a clearing pass writes zero to all MAX_BINS*MAX_BINS entries
//  (4096 entries by default); in_ch.ready stays low, cfg_ch.ready stays high.
// ----------------------------------------------------------------------------
module histogram_2d_binner #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  h2b_in_if.sink    in_ch,
  h2b_out_if.source out_ch,
  h2b_cfg_if.sink   cfg_ch
);

  localparam int DEPTH  = MAX_BINS * MAX_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int EXT_W  = (COUNT_BITS > h2b_pkg::OUT_W) ? COUNT_BITS : h2b_pkg::OUT_W;
  localparam logic [31:0] MAX_BINS_U = 32'(MAX_BINS);
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_N = 2;
  localparam int LANES  = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_BINS,
    ST_INDEX,
    ST_FETCH,
    ST_UPDATE,
    ST_RD_WAIT
  } state_t;

  state_t state_r;

  h2b_pkg::sample_t    range_start_r;
  h2b_pkg::sample_t    range_end_r;
  h2b_pkg::bin_width_t bin_width_r;

  logic [ADDR_W-1:0]             clr_addr_r;
  logic [h2b_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [h2b_pkg::DIV_W-1:0]     div_rem_r [LANES];
  logic [h2b_pkg::DIV_W-1:0]     div_quo_r [LANES];
  logic [h2b_pkg::DIV_W-1:0]     div_rem_nxt [LANES];
  logic [h2b_pkg::DIV_W-1:0]     div_quo_nxt [LANES];
  logic [h2b_pkg::DIV_W:0]       div_shift;

  logic              lo_x_r, hi_x_r, lo_y_r, hi_y_r, empty_r;
  logic [IDX_W-1:0]  nm1_r;
  logic [IDX_W-1:0]  ix_r, iy_r;
  logic [ADDR_W-1:0] addr_r;
  logic              rd_oob_r;

  logic                       out_valid_r;
  h2b_pkg::count_out_t        bin_count_r;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] mem_rd_r;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_wa, mem_ra;
  logic [COUNT_BITS-1:0] mem_wd;

  h2b_pkg::bin_width_t   width_eff;
  logic                  in_acc;
  logic                  rd_fire;
  logic [31:0]           rd_lin;
  logic [31:0]           upd_lin;
  logic [EXT_W-1:0]      rd_ext;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_count = bin_count_r;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign rd_fire   = (state_r == ST_RD_WAIT) && (!out_valid_r || out_ch.ready);
  assign width_eff = (bin_width_r == '0) ? h2b_pkg::bin_width_t'(1) : bin_width_r;
  assign rd_lin    = 32'(in_ch.read_row) * MAX_BINS_U + 32'(in_ch.read_col);
  assign upd_lin   = 32'(ix_r) * MAX_BINS_U + 32'(iy_r);
  assign rd_ext    = EXT_W'(mem_rd_r);

  // one restoring division step per lane, shared divisor
  always_comb begin
    div_shift = '0;
    for (int l = 0; l < LANES; l++) begin
      div_shift = {div_rem_r[l], div_quo_r[l][h2b_pkg::DIV_W-1]};
      if (div_shift >= {2'b00, width_eff}) begin
        div_rem_nxt[l] = h2b_pkg::DIV_W'(div_shift - {2'b00, width_eff});
        div_quo_nxt[l] = {div_quo_r[l][h2b_pkg::DIV_W-2:0], 1'b1};
      end else begin
        div_rem_nxt[l] = div_shift[h2b_pkg::DIV_W-1:0];
        div_quo_nxt[l] = {div_quo_r[l][h2b_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = upd_lin[ADDR_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
      end
      ST_IDLE: begin
        mem_re = in_acc && (in_ch.operation == h2b_pkg::OP_READ);
        mem_ra = rd_lin[ADDR_W-1:0];
      end
      ST_FETCH: begin
        mem_re = 1'b1;
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
        mem_wd = (mem_rd_r == '1) ? mem_rd_r : mem_rd_r + COUNT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      range_start_r <= '0;
      range_end_r   <= h2b_pkg::sample_t'(64);
      bin_width_r   <= h2b_pkg::bin_width_t'(1);
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          h2b_pkg::CFG_RANGE_START: range_start_r <= h2b_pkg::sample_t'(cfg_ch.data);
          h2b_pkg::CFG_RANGE_END:   range_end_r   <= h2b_pkg::sample_t'(cfg_ch.data);
          h2b_pkg::CFG_BIN_WIDTH:   bin_width_r   <= cfg_ch.data[h2b_pkg::WIDTH_W-1:0];
          default: begin
          end
        endcase
      end

      if (rd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.operation == h2b_pkg::OP_READ) begin
              rd_oob_r <= (32'(in_ch.read_row) >= MAX_BINS_U) ||
                          (32'(in_ch.read_col) >= MAX_BINS_U);
              state_r  <= ST_RD_WAIT;
            end else begin
              lo_x_r  <= in_ch.sample_x < range_start_r;
              hi_x_r  <= in_ch.sample_x >= range_end_r;
              lo_y_r  <= in_ch.sample_y < range_start_r;
              hi_y_r  <= in_ch.sample_y >= range_end_r;
              empty_r <= range_end_r <= range_start_r;
              div_rem_r[LANE_X] <= '0;
              div_rem_r[LANE_Y] <= '0;
              div_rem_r[LANE_N] <= '0;
              div_quo_r[LANE_X] <= 32'(in_ch.sample_x - range_start_r);
              div_quo_r[LANE_Y] <= 32'(in_ch.sample_y - range_start_r);
              div_quo_r[LANE_N] <= 32'(range_end_r - range_start_r);
              div_cnt_r <= '0;
              state_r   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          for (int l = 0; l < LANES; l++) begin
            div_rem_r[l] <= div_rem_nxt[l];
            div_quo_r[l] <= div_quo_nxt[l];
          end
          div_cnt_r <= div_cnt_r + h2b_pkg::DIV_CNT_W'(1);
          if (div_cnt_r == h2b_pkg::DIV_CNT_W'(h2b_pkg::DIV_W - 1)) begin
            state_r <= ST_BINS;
          end
        end
        ST_BINS: begin
          if (empty_r || div_quo_r[LANE_N] == '0) begin
            nm1_r <= '0;
          end else if (div_quo_r[LANE_N] > MAX_BINS_U) begin
            nm1_r <= IDX_W'(MAX_BINS - 1);
          end else begin
            nm1_r <= IDX_W'(div_quo_r[LANE_N] - 32'd1);
          end
          state_r <= ST_INDEX;
        end
        ST_INDEX: begin
          if (lo_x_r) begin
            ix_r <= '0;
          end else if (hi_x_r || div_quo_r[LANE_X] > 32'(nm1_r)) begin
            ix_r <= nm1_r;
          end else begin
            ix_r <= div_quo_r[LANE_X][IDX_W-1:0];
          end
          if (lo_y_r) begin
            iy_r <= '0;
          end else if (hi_y_r || div_quo_r[LANE_Y] > 32'(nm1_r)) begin
            iy_r <= nm1_r;
          end else begin
            iy_r <= div_quo_r[LANE_Y][IDX_W-1:0];
          end
          state_r <= ST_FETCH;
        end
        ST_FETCH: begin
          addr_r  <= upd_lin[ADDR_W-1:0];
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state_r <= ST_IDLE;
        end
        ST_RD_WAIT: begin
          if (rd_fire) begin
            bin_count_r <= rd_oob_r ? '0 : rd_ext[h2b_pkg::OUT_W-1:0];
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/h2b_checker.sv -----
// ----------------------------------------------------------------------------
// h2b_checker
// Port-level checks on the 2D histogram binner, bound to the top level.
// ----------------------------------------------------------------------------
module h2b_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input h2b_pkg::op_t        in_operation,
  input logic                out_valid,
  input logic                out_ready,
  input h2b_pkg::count_out_t out_bin_count
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_bin_count)))
    else $error("result dropped or changed while stalled");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second transaction taken while busy");

  // read with free output register shows a result after the RAM read and the output register
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == h2b_pkg::OP_READ && !out_valid) |-> ##2 out_valid)
    else $error("read transaction gave no result");

  // add needs the divider: input ready must stay low just after an add is taken
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == h2b_pkg::OP_ADD) |=> !in_ready ##1 !in_ready)
    else $error("add transaction finished too early");

endmodule

bind histogram_2d_binner h2b_checker u_h2b_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_operation  (in_ch.operation),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_bin_count (out_ch.bin_count)
);

// ----- tb/sv/histogram_2d_binner_tb.sv -----
// ----------------------------------------------------------------------------
// histogram_2d_binner_tb
// Self-checking bench for the 2D histogram binner. A bin predictor keeps its
// own copy of the range registers and the counter grid. It is updated on every
// accepted add and config transaction, and queues the expected count for
// every accepted read. Directed tests cover the default range, the field
// extremes, clamped edge bins, zero width, an empty range and full-span
// registers. Random phases then sweep several register settings with random
// gaps on the input, config and output channels.
// ----------------------------------------------------------------------------
module histogram_2d_binner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               GRID          = 64;
  localparam int               CNT_BITS      = 32;
  localparam int               ADD_LATENCY   = 48;
  localparam int               QUIET_LIMIT   = 20000;
  localparam int               RANDOM_PHASES = 6;
  localparam int               PHASE_ITEMS   = 171;
  localparam longint           S_MIN         = -64'sd2147483648;
  localparam longint           S_MAX         = 64'sd2147483647;
  localparam h2b_pkg::sample_t SMP_MIN       = 32'h8000_0000;
  localparam h2b_pkg::sample_t SMP_MAX       = 32'h7fff_ffff;

  logic clk = 1'b0;
  logic rst_n;

  h2b_in_if  in_ch ();
  h2b_out_if out_ch ();
  h2b_cfg_if cfg_ch ();

  histogram_2d_binner #(
    .MAX_BINS  (GRID),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  int                  cur_start;
  int                  cur_end;
  int unsigned         cur_width;
  logic [CNT_BITS-1:0] bin_tally [GRID*GRID];
  h2b_pkg::count_out_t count_q [$];
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  bit                  steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint width_eff();
    return (cur_width == 0) ? 64'sd1 : longint'(cur_width);
  endfunction

  function automatic longint bins_in_use();
    longint n;
    if (cur_end <= cur_start) return 1;
    n = (longint'(cur_end) - longint'(cur_start)) / width_eff();
    if (n > GRID) n = GRID;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic longint axis_bin(int v, longint n);
    longint idx;
    if (v < cur_start) return 0;
    if (v >= cur_end) return n - 1;
    idx = (longint'(v) - longint'(cur_start)) / width_eff();
    return (idx > n - 1) ? n - 1 : idx;
  endfunction

  function automatic void predict_item(h2b_pkg::op_t op, h2b_pkg::sample_t sx,
                                       h2b_pkg::sample_t sy, h2b_pkg::rowcol_t row,
                                       h2b_pkg::rowcol_t col);
    longint n;
    longint addr;
    if (op == h2b_pkg::OP_ADD) begin
      n    = bins_in_use();
      addr = axis_bin(sx, n) * GRID + axis_bin(sy, n);
      if (bin_tally[addr] != '1) bin_tally[addr] = bin_tally[addr] + 1'b1;
    end else begin
      count_q.insert(count_q.size(), bin_tally[int'(row) * GRID + int'(col)]);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic h2b_pkg::sample_t pick_sample();
    longint          lo;
    longint          hi;
    longint          tmp;
    longint unsigned span_u;
    longint unsigned r;
    case ($urandom_range(0, 9))
      0: return h2b_pkg::sample_t'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0:       return h2b_pkg::sample_t'(cur_start);
          1:       return h2b_pkg::sample_t'(cur_end);
          2:       return h2b_pkg::sample_t'(cur_end - 1);
          3:       return h2b_pkg::sample_t'(cur_start - 1);
          4:       return SMP_MIN;
          default: return SMP_MAX;
        endcase
      end
      default: begin
        lo = longint'(cur_start) - width_eff();
        hi = longint'(cur_end) + width_eff();
        if (hi < lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        if (lo < S_MIN) lo = S_MIN;
        if (hi > S_MAX) hi = S_MAX;
        span_u = hi - lo + 1;
        r      = {$urandom, $urandom} % span_u;
        return h2b_pkg::sample_t'(lo + longint'(r));
      end
    endcase
  endfunction

  function automatic h2b_pkg::rowcol_t pick_index(longint n);
    if ($urandom_range(0, 9) < 7) return h2b_pkg::rowcol_t'($urandom_range(0, n - 1));
    return h2b_pkg::rowcol_t'($urandom);
  endfunction

  task automatic send_item(h2b_pkg::op_t op, h2b_pkg::sample_t sx, h2b_pkg::sample_t sy,
                           h2b_pkg::rowcol_t row, h2b_pkg::rowcol_t col);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.sample_x  <= sx;
    in_ch.sample_y  <= sy;
    in_ch.read_row  <= row;
    in_ch.read_col  <= col;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, sx, sy, row, col);
  endtask

  task automatic write_reg(h2b_pkg::cfg_idx_t idx, logic [31:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      h2b_pkg::CFG_RANGE_START: cur_start = int'(val);
      h2b_pkg::CFG_RANGE_END:   cur_end   = int'(val);
      h2b_pkg::CFG_BIN_WIDTH:   cur_width = {1'b0, val[h2b_pkg::WIDTH_W-1:0]};
      default: ;
    endcase
  endtask

  task automatic apply_config(int s, int e, logic [31:0] w);
    write_reg(h2b_pkg::CFG_RANGE_START, s);
    write_reg(h2b_pkg::CFG_RANGE_END, e);
    write_reg(h2b_pkg::CFG_BIN_WIDTH, w);
    cfg_ch.valid <= 1'b0;
  endtask

  // drain pending reads, then let a trailing add finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (count_q.size() != 0) @(posedge clk);
    repeat (ADD_LATENCY) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, h2b_pkg::count_out_t got,
                                 h2b_pkg::count_out_t want);
    mismatches++;
    $display("%0t ERROR bin_count %s: got %h want %h", $time, what, got, want);
  endtask

  initial begin : out_stall
    int hold;
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (count_q.size() == 0) begin
        report_mismatch("with no pending read", out_ch.bin_count, 'x);
      end else begin
        if (out_ch.bin_count !== count_q[0])
          report_mismatch("differs", out_ch.bin_count, count_q[0]);
        void'(count_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("histogram_2d_binner: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_default_binning();
    send_item(h2b_pkg::OP_READ, 0, 0, 0, 0);
    send_item(h2b_pkg::OP_ADD, SMP_MIN, SMP_MAX, 0, 0);
    send_item(h2b_pkg::OP_ADD, 0, 63, 6'h3f, 6'h3f);
    send_item(h2b_pkg::OP_ADD, 64, -1, 0, 0);
    send_item(h2b_pkg::OP_ADD, 63, 0, 0, 0);
    send_item(h2b_pkg::OP_ADD, 5, 7, 0, 0);
    send_item(h2b_pkg::OP_READ, SMP_MAX, SMP_MIN, 0, 63);
    send_item(h2b_pkg::OP_READ, 0, 0, 63, 0);
    send_item(h2b_pkg::OP_READ, 0, 0, 5, 7);
    send_item(h2b_pkg::OP_READ, 0, 0, 63, 63);
  endtask

  task automatic test_config_corners();
    settle();
    apply_config(0, 10, 3);
    send_item(h2b_pkg::OP_ADD, 9, 9, 0, 0);
    send_item(h2b_pkg::OP_ADD, 10, 8, 0, 0);
    send_item(h2b_pkg::OP_ADD, -1, 3, 0, 0);
    send_item(h2b_pkg::OP_READ, 0, 0, 2, 2);
    send_item(h2b_pkg::OP_READ, 0, 0, 0, 1);
    settle();
    apply_config(100, 100, 5);
    send_item(h2b_pkg::OP_ADD, 500, -500, 0, 0);
    send_item(h2b_pkg::OP_READ, 0, 0, 0, 0);
    settle();
    apply_config(0, 20, 0);
    send_item(h2b_pkg::OP_ADD, 19, 25, 0, 0);
    send_item(h2b_pkg::OP_READ, 0, 0, 19, 19);
    settle();
    apply_config(int'(SMP_MIN), int'(SMP_MAX), 32'h7fff_ffff);
    send_item(h2b_pkg::OP_ADD, SMP_MAX, SMP_MIN, 0, 0);
    send_item(h2b_pkg::OP_ADD, -1, 0, 0, 0);
    send_item(h2b_pkg::OP_READ, 0, 0, 1, 0);
    send_item(h2b_pkg::OP_READ, 0, 0, 5, 7);
  endtask

  task automatic test_random_traffic();
    int          s;
    int          e;
    int          w;
    int          nb;
    logic [31:0] wdata;
    longint      n;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          w     = $urandom_range(1, 20);
          s     = int'($urandom_range(0, 2000)) - 1000;
          nb    = $urandom_range(1, GRID);
          e     = s + nb * w + int'($urandom_range(0, w - 1));
          wdata = w;
        end
        1: begin
          w     = $urandom_range(1, 1000);
          s     = int'($urandom) >>> 2;
          e     = s + (GRID + int'($urandom_range(1, 200))) * w;
          wdata = w;
        end
        2: begin
          s     = int'(SMP_MIN);
          e     = int'(SMP_MAX);
          wdata = $urandom_range(32'h0200_0000, 32'h7fff_ffff);
        end
        3: begin
          s     = int'($urandom) >>> 1;
          e     = s - int'($urandom_range(0, 1000));
          wdata = $urandom_range(1, 50);
        end
        4: begin
          s     = int'($urandom_range(0, 200)) - 100;
          e     = s + int'($urandom_range(1, 80));
          wdata = 32'h8000_0000;
        end
        default: begin
          s     = int'($urandom);
          e     = int'($urandom);
          wdata = $urandom;
        end
      endcase
      apply_config(s, e, wdata);
      n = bins_in_use();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 6)
          send_item(h2b_pkg::OP_ADD, pick_sample(), pick_sample(),
                    h2b_pkg::rowcol_t'($urandom), h2b_pkg::rowcol_t'($urandom));
        else
          send_item(h2b_pkg::OP_READ, h2b_pkg::sample_t'($urandom),
                    h2b_pkg::sample_t'($urandom), pick_index(n), pick_index(n));
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = h2b_pkg::OP_ADD;
    in_ch.sample_x   = '0;
    in_ch.sample_y   = '0;
    in_ch.read_row   = '0;
    in_ch.read_col   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = h2b_pkg::CFG_RANGE_START;
    cfg_ch.data      = '0;
    cur_start        = 0;
    cur_end          = 64;
    cur_width        = 1;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_binning();
    test_config_corners();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("histogram_2d_binner: match");
    end else begin
      $display("histogram_2d_binner: mismatch");
    end
    $finish;
  end

endmodule
